@@ rtl/scx_pkg.sv @@
// Shared types, codes and helper functions of the AdvSIMD copy-group execute block.
package scx_pkg;

	localparam logic [31:0] COPY_MASK  = 32'h9FE0_8400;
	localparam logic [31:0] COPY_MATCH = 32'h0E00_0400;

	// imm4 encodings of the copy group when op is clear.
	localparam logic [3:0] IMM4_DUP_ELEM = 4'd0;
	localparam logic [3:0] IMM4_DUP_GEN  = 4'd1;
	localparam logic [3:0] IMM4_INS_GEN  = 4'd3;
	localparam logic [3:0] IMM4_SMOV     = 4'd5;
	localparam logic [3:0] IMM4_UMOV     = 4'd7;

	localparam logic [1:0] SIZE_D = 2'd3;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_UNDEF     = 2'd1,
		STATUS_UNHANDLED = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] instruction;
		logic [31:0] decode_word;
		logic        scalar_form;
		logic        q_bit;
		logic [63:0] program_counter;
		logic [63:0] source_vec_low;
		logic [63:0] source_vec_high;
		logic [63:0] dest_vec_low;
		logic [63:0] dest_vec_high;
		logic [63:0] general_source;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [4:0]  dest_index;
		logic        vec_write_enable;
		logic [63:0] result_vec_low;
		logic [63:0] result_vec_high;
		logic        gpr_write_enable;
		logic [63:0] gpr_result;
		logic [63:0] next_pc;
	} result_t;

	function automatic logic [63:0] elem_mask(input logic [1:0] size);
		logic [63:0] m;
		unique case (size)
			2'd0: m = 64'h0000_0000_0000_00FF;
			2'd1: m = 64'h0000_0000_0000_FFFF;
			2'd2: m = 64'h0000_0000_FFFF_FFFF;
			default: m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [63:0] replicate(input logic [63:0] e, input logic [1:0] size);
		logic [63:0] r;
		unique case (size)
			2'd0: r = {8{e[7:0]}};
			2'd1: r = {4{e[15:0]}};
			2'd2: r = {2{e[31:0]}};
			default: r = e;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] sign_extend(input logic [63:0] e, input logic [1:0] size);
		logic [63:0] r;
		unique case (size)
			2'd0: r = {{56{e[7]}}, e[7:0]};
			2'd1: r = {{48{e[15]}}, e[15:0]};
			2'd2: r = {{32{e[31]}}, e[31:0]};
			default: r = e;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/simd_copy_execute.sv @@
// Top level of the AdvSIMD copy-group execute block: input register, datapath, result register.
//
// The block executes DUP, INS, SMOV and UMOV of the AArch64 AdvSIMD copy group.
// The issue side presents one word on item (instruction, pre-decode word, flags,
// PC and register operands) with item_valid; it is taken when item_ready is high.
// The block returns one word on result with result_valid for every word taken:
// status, destination register, vector and general write data with their write
// enables, and the next PC.
// A word taken is held in the input register, passes the decode and lane muxes,
// and is loaded into the result register once that register is free; the
// receiver takes it from there.
// Throughput is one word per cycle while result_ready stays high; the two registers
// form a pipeline whose ready chains back from result_ready.
// When the receiver stalls, the result word holds and the input register fills;
// item_ready drops only once both stages hold words.
// Reset empties both stages; no word is lost or repeated after it.
module simd_copy_execute (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  scx_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output scx_pkg::result_t result
);

	scx_pkg::item_t   item_s1;
	logic             valid_s1;
	scx_pkg::result_t exec_result;
	scx_pkg::result_t result_s2;
	logic             valid_s2;
	logic             ready_s2;
	logic             ready_s1;

	assign ready_s2   = !valid_s2 || result_ready;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign item_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= item_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && item_valid) begin
			item_s1 <= item;
		end
		if (ready_s2 && valid_s1) begin
			result_s2 <= exec_result;
		end
	end

	scx_exec u_exec (
		.item   (item_s1),
		.result (exec_result)
	);

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

@@ rtl/scx_exec.sv @@
// Combinational decode and lane datapath of the copy-group execute block.
module scx_exec (
	input  scx_pkg::item_t   item,
	output scx_pkg::result_t result
);

	logic [4:0]  rd;
	logic        op;
	logic [3:0]  imm4;
	logic [4:0]  imm5;
	logic        imm5_ok;
	logic [1:0]  size;
	logic [3:0]  index;
	logic [3:0]  src_idx;
	logic [3:0]  fetch_idx;
	logic [3:0]  off_get;
	logic [3:0]  off_set;
	logic [5:0]  sh_get;
	logic [5:0]  sh_set;
	logic [63:0] emask;
	logic [63:0] half;
	logic [63:0] elem;
	logic [63:0] gen_elem;
	logic [63:0] ins_val;
	logic [63:0] lane_mask;
	logic [63:0] ins_lo;
	logic [63:0] ins_hi;
	logic [63:0] dup_val;
	logic [63:0] mov_val;
	logic        imm4_alloc;

	assign rd   = item.instruction[4:0];
	assign op   = item.instruction[29];
	assign imm4 = item.instruction[14:11];
	assign imm5 = item.instruction[20:16];

	// Element size is the position of the lowest set bit of imm5, the index sits above it.
	always_comb begin
		imm5_ok = 1'b1;
		size    = 2'd0;
		index   = 4'd0;
		priority if (imm5[0]) begin
			size  = 2'd0;
			index = imm5[4:1];
		end else if (imm5[1]) begin
			size  = 2'd1;
			index = {1'b0, imm5[4:2]};
		end else if (imm5[2]) begin
			size  = 2'd2;
			index = {2'b00, imm5[4:3]};
		end else if (imm5[3]) begin
			size  = 2'd3;
			index = {3'b000, imm5[4]};
		end else begin
			imm5_ok = 1'b0;
		end
	end

	assign emask     = scx_pkg::elem_mask(size);
	assign src_idx   = imm4 >> size;
	assign fetch_idx = op ? src_idx : index;

	// Byte offsets of the source and destination lanes within the 128-bit register.
	assign off_get = 4'(fetch_idx << size);
	assign off_set = 4'(index << size);
	assign sh_get  = {off_get[2:0], 3'b000};
	assign sh_set  = {off_set[2:0], 3'b000};

	assign half     = off_get[3] ? item.source_vec_high : item.source_vec_low;
	assign elem     = (half >> sh_get) & emask;
	assign gen_elem = item.general_source & emask;

	assign ins_val   = op ? elem : gen_elem;
	assign lane_mask = emask << sh_set;
	assign ins_lo = off_set[3] ? item.dest_vec_low :
		((item.dest_vec_low & ~lane_mask) | ((ins_val << sh_set) & lane_mask));
	assign ins_hi = off_set[3] ?
		((item.dest_vec_high & ~lane_mask) | ((ins_val << sh_set) & lane_mask)) :
		item.dest_vec_high;

	assign dup_val = (imm4 == scx_pkg::IMM4_DUP_ELEM) ? elem : gen_elem;
	assign mov_val = (imm4 == scx_pkg::IMM4_SMOV) ? scx_pkg::sign_extend(elem, size) : elem;

	assign imm4_alloc = (imm4 == scx_pkg::IMM4_DUP_ELEM) || (imm4 == scx_pkg::IMM4_DUP_GEN) ||
		(imm4 == scx_pkg::IMM4_INS_GEN) || (imm4 == scx_pkg::IMM4_SMOV) ||
		(imm4 == scx_pkg::IMM4_UMOV);

	always_comb begin
		result                  = '0;
		result.status           = scx_pkg::STATUS_OK;
		result.next_pc          = item.program_counter;
		if ((item.decode_word & scx_pkg::COPY_MASK) != scx_pkg::COPY_MATCH) begin
			result.status = scx_pkg::STATUS_UNHANDLED;
		end else if (!imm5_ok || (!op && !imm4_alloc)) begin
			result.status = scx_pkg::STATUS_UNDEF;
		end else if (op) begin
			result.vec_write_enable = 1'b1;
			result.result_vec_low   = ins_lo;
			result.result_vec_high  = ins_hi;
		end else begin
			unique case (imm4)
				scx_pkg::IMM4_DUP_ELEM, scx_pkg::IMM4_DUP_GEN: begin
					// A 1D arrangement exists only for the scalar spelling.
					if (size == scx_pkg::SIZE_D && !item.q_bit &&
						!(imm4 == scx_pkg::IMM4_DUP_ELEM && item.scalar_form)) begin
						result.status = scx_pkg::STATUS_UNDEF;
					end else if (imm4 == scx_pkg::IMM4_DUP_ELEM && item.scalar_form) begin
						result.vec_write_enable = 1'b1;
						result.result_vec_low   = dup_val;
					end else begin
						result.vec_write_enable = 1'b1;
						result.result_vec_low   = scx_pkg::replicate(dup_val, size);
						result.result_vec_high  = item.q_bit ?
							scx_pkg::replicate(dup_val, size) : 64'd0;
					end
				end
				scx_pkg::IMM4_INS_GEN: begin
					result.vec_write_enable = 1'b1;
					result.result_vec_low   = ins_lo;
					result.result_vec_high  = ins_hi;
				end
				scx_pkg::IMM4_SMOV, scx_pkg::IMM4_UMOV: begin
					result.gpr_write_enable = 1'b1;
					result.gpr_result = item.q_bit ? mov_val : {32'd0, mov_val[31:0]};
				end
				default: begin
					result.status = scx_pkg::STATUS_UNDEF;
				end
			endcase
		end
		if (result.status == scx_pkg::STATUS_OK) begin
			result.dest_index = rd;
			result.next_pc    = item.program_counter + 64'd4;
		end
	end

endmodule

@@ rtl/scx_checker.sv @@
// Port-level checker of the copy-group execute block and its bind to the top level.
module scx_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_ready,
	input scx_pkg::result_t result
);

	// A stalled result word must stay put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// A failed instruction writes nothing and names no register.
	a_fail_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != scx_pkg::STATUS_OK |->
		!result.vec_write_enable && !result.gpr_write_enable && result.dest_index == 5'd0)
		else $error("failed instruction carries a write");

	// An executed copy instruction writes exactly one register file.
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == scx_pkg::STATUS_OK |->
		result.vec_write_enable != result.gpr_write_enable)
		else $error("executed instruction must write exactly one register file");

	// Data of a register file that is not written is zero.
	a_idle_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
		(result.vec_write_enable ||
			(result.result_vec_low == 64'd0 && result.result_vec_high == 64'd0)) &&
		(result.gpr_write_enable || result.gpr_result == 64'd0))
		else $error("unwritten result data not zero");

endmodule

bind simd_copy_execute scx_checker u_scx_checker (.*);

@@ tb/tb.sv @@
// Self-checking testbench for the AdvSIMD copy-group execute block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	class writeback_tracker;
		scx_pkg::result_t owed_writebacks[$];
		int unsigned mismatches;
		int unsigned words_checked;

		// Expected writeback for one issued word, computed from the architectural rules.
		function scx_pkg::result_t predict_writeback(scx_pkg::item_t w);
			scx_pkg::result_t r;
			logic [127:0] src;
			logic [127:0] dst;
			logic [63:0] emask;
			logic [63:0] e;
			logic [63:0] d;
			logic [63:0] rep;
			logic [63:0] g;
			logic [4:0] imm5;
			logic [3:0] imm4;
			logic op;
			logic found;
			int unsigned size;
			int unsigned index;
			int unsigned bits;
			int unsigned src_idx;
			int unsigned off;
			r = '0;
			r.status = scx_pkg::STATUS_OK;
			r.next_pc = w.program_counter;
			if ((w.decode_word & scx_pkg::COPY_MASK) != scx_pkg::COPY_MATCH) begin
				r.status = scx_pkg::STATUS_UNHANDLED;
				return r;
			end
			imm5 = w.instruction[20:16];
			imm4 = w.instruction[14:11];
			op = w.instruction[29];
			found = 1'b0;
			size = 0;
			// Walk down so that the lowest set bit of imm5 wins.
			for (int s = 3; s >= 0; s--) begin
				if (imm5[s]) begin
					size = s;
					found = 1'b1;
				end
			end
			if (!found || (!op && imm4 != scx_pkg::IMM4_DUP_ELEM &&
					imm4 != scx_pkg::IMM4_DUP_GEN && imm4 != scx_pkg::IMM4_INS_GEN &&
					imm4 != scx_pkg::IMM4_SMOV && imm4 != scx_pkg::IMM4_UMOV)) begin
				r.status = scx_pkg::STATUS_UNDEF;
				return r;
			end
			index = imm5 >> (size + 1);
			bits = 8 << size;
			emask = (size == scx_pkg::SIZE_D) ? '1 : ((64'd1 << bits) - 64'd1);
			src = {w.source_vec_high, w.source_vec_low};
			src_idx = op ? (imm4 >> size) : index;
			off = ((src_idx << size) & 15) * 8;
			e = 64'(src >> off) & emask;
			dst = '0;
			g = '0;
			if (op || imm4 == scx_pkg::IMM4_INS_GEN) begin
				d = op ? e : (w.general_source & emask);
				off = ((index << size) & 15) * 8;
				dst = {w.dest_vec_high, w.dest_vec_low};
				dst = (dst & ~(128'(emask) << off)) | (128'(d) << off);
				r.vec_write_enable = 1'b1;
			end else if (imm4 == scx_pkg::IMM4_DUP_ELEM || imm4 == scx_pkg::IMM4_DUP_GEN) begin
				if (size == scx_pkg::SIZE_D && !w.q_bit &&
						!(imm4 == scx_pkg::IMM4_DUP_ELEM && w.scalar_form)) begin
					r.status = scx_pkg::STATUS_UNDEF;
					return r;
				end
				d = (imm4 == scx_pkg::IMM4_DUP_ELEM) ? e : (w.general_source & emask);
				if (imm4 == scx_pkg::IMM4_DUP_ELEM && w.scalar_form) begin
					dst = {64'd0, d};
				end else begin
					rep = '0;
					for (int k = 0; k < 64 / bits; k++) begin
						rep = rep | (d << (k * bits));
					end
					dst = {w.q_bit ? rep : 64'd0, rep};
				end
				r.vec_write_enable = 1'b1;
			end else begin
				if (imm4 == scx_pkg::IMM4_SMOV && size != scx_pkg::SIZE_D && e[bits - 1]) begin
					e = e | ~emask;
				end
				g = w.q_bit ? e : {32'd0, e[31:0]};
				r.gpr_write_enable = 1'b1;
			end
			r.dest_index = w.instruction[4:0];
			r.result_vec_low = dst[63:0];
			r.result_vec_high = dst[127:64];
			r.gpr_result = g;
			r.next_pc = w.program_counter + 64'd4;
			return r;
		endfunction

		function void note_issue(scx_pkg::item_t w);
			owed_writebacks.push_back(predict_writeback(w));
		endfunction

		task flag_mismatch(string msg);
			mismatches++;
			if (mismatches <= 40) begin
				$display("mismatch on writeback word %0d: %s", words_checked, msg);
			end
		endtask

		task compare_field(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want) begin
				flag_mismatch($sformatf("%s is %h, expected %h", name, got, want));
			end
		endtask

		task check_writeback(scx_pkg::result_t got);
			scx_pkg::result_t want;
			if (owed_writebacks.size() == 0) begin
				flag_mismatch("writeback word with nothing outstanding");
			end else begin
				want = owed_writebacks.pop_front();
				compare_field("status", got.status, want.status);
				compare_field("dest_index", got.dest_index, want.dest_index);
				compare_field("vec_write_enable", got.vec_write_enable, want.vec_write_enable);
				compare_field("result_vec_low", got.result_vec_low, want.result_vec_low);
				compare_field("result_vec_high", got.result_vec_high, want.result_vec_high);
				compare_field("gpr_write_enable", got.gpr_write_enable, want.gpr_write_enable);
				compare_field("gpr_result", got.gpr_result, want.gpr_result);
				compare_field("next_pc", got.next_pc, want.next_pc);
			end
			words_checked++;
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	scx_pkg::item_t item;
	logic result_valid;
	logic result_ready;
	scx_pkg::result_t result;
	bit calm = 1'b0;
	writeback_tracker tracker = new();

	simd_copy_execute u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("** simd_copy_execute: FAILED **");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) begin
				tracker.note_issue(item);
			end
			if (result_valid && result_ready) begin
				tracker.check_writeback(result);
			end
		end
	end

	// Receiver: random stall bursts until the closing stretch.
	initial begin
		result_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			result_ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	function automatic logic [63:0] wide_value();
		logic [63:0] v;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			default: v = {$urandom(), $urandom()};
		endcase
		return v;
	endfunction

	function automatic scx_pkg::item_t copy_word(bit op, logic [3:0] imm4, logic [4:0] imm5,
			bit q, bit scalar);
		scx_pkg::item_t w;
		w.instruction = $urandom();
		w.instruction[29] = op;
		w.instruction[14:11] = imm4;
		w.instruction[20:16] = imm5;
		w.decode_word = ($urandom() & ~scx_pkg::COPY_MASK) | scx_pkg::COPY_MATCH;
		w.scalar_form = scalar;
		w.q_bit = q;
		w.program_counter = wide_value();
		w.source_vec_low = wide_value();
		w.source_vec_high = wide_value();
		w.dest_vec_low = wide_value();
		w.dest_vec_high = wide_value();
		w.general_source = wide_value();
		return w;
	endfunction

	function automatic scx_pkg::item_t random_word();
		scx_pkg::item_t w;
		logic [3:0] imm4;
		logic [4:0] imm5;
		int unsigned size;
		int unsigned pick;
		int b;
		bit op;
		pick = $urandom_range(0, 99);
		op = ($urandom_range(0, 3) == 0);
		if (op) begin
			imm4 = 4'($urandom());
		end else begin
			case ($urandom_range(0, 10))
				0, 1: imm4 = scx_pkg::IMM4_DUP_ELEM;
				2, 3: imm4 = scx_pkg::IMM4_DUP_GEN;
				4, 5: imm4 = scx_pkg::IMM4_INS_GEN;
				6, 7: imm4 = scx_pkg::IMM4_SMOV;
				8, 9: imm4 = scx_pkg::IMM4_UMOV;
				default: imm4 = 4'($urandom());
			endcase
		end
		size = $urandom_range(0, 3);
		imm5 = 5'(($urandom() << (size + 1)) | (1 << size));
		if ($urandom_range(0, 19) == 0) begin
			imm5 = 5'($urandom());
		end
		w = copy_word(op, imm4, imm5, $urandom_range(0, 1), $urandom_range(0, 3) == 0);
		if (pick >= 90) begin
			// Near miss: one bit of the copy-group pattern is wrong.
			do b = $urandom_range(0, 31); while (!scx_pkg::COPY_MASK[b]);
			w.decode_word[b] = ~w.decode_word[b];
		end else if (pick >= 80) begin
			w.decode_word = $urandom();
			w.instruction = $urandom();
		end
		return w;
	endfunction

	task issue_word(scx_pkg::item_t w);
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (!item_ready);
	endtask

	initial begin
		scx_pkg::item_t w;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every operation, DUP of an element at each size, undefined and unhandled encodings.
		issue_word(copy_word(1'b0, scx_pkg::IMM4_DUP_ELEM, 5'b11111, 1'b1, 1'b0));
		issue_word(copy_word(1'b0, scx_pkg::IMM4_DUP_ELEM, 5'b11110, 1'b0, 1'b0));
		issue_word(copy_word(1'b0, scx_pkg::IMM4_DUP_ELEM, 5'b11100, 1'b1, 1'b0));
		issue_word(copy_word(1'b0, scx_pkg::IMM4_DUP_ELEM, 5'b11000, 1'b1, 1'b0));
		issue_word(copy_word(1'b0, scx_pkg::IMM4_DUP_ELEM, 5'b01000, 1'b0, 1'b0));
		issue_word(copy_word(1'b0, scx_pkg::IMM4_DUP_ELEM, 5'b11000, 1'b0, 1'b1));
		issue_word(copy_word(1'b0, scx_pkg::IMM4_DUP_ELEM, 5'b00001, 1'b1, 1'b1));
		issue_word(copy_word(1'b0, scx_pkg::IMM4_DUP_GEN, 5'b00001, 1'b1, 1'b0));
		issue_word(copy_word(1'b0, scx_pkg::IMM4_DUP_GEN, 5'b01000, 1'b0, 1'b1));
		issue_word(copy_word(1'b0, scx_pkg::IMM4_INS_GEN, 5'b11110, 1'b0, 1'b0));
		issue_word(copy_word(1'b0, scx_pkg::IMM4_INS_GEN, 5'b11000, 1'b1, 1'b0));
		issue_word(copy_word(1'b0, scx_pkg::IMM4_SMOV, 5'b11100, 1'b0, 1'b0));
		issue_word(copy_word(1'b0, scx_pkg::IMM4_UMOV, 5'b01000, 1'b1, 1'b0));
		issue_word(copy_word(1'b0, scx_pkg::IMM4_UMOV, 5'b00110, 1'b0, 1'b1));
		issue_word(copy_word(1'b1, 4'hF, 5'b11111, 1'b0, 1'b0));
		issue_word(copy_word(1'b1, 4'h8, 5'b11000, 1'b1, 1'b0));
		issue_word(copy_word(1'b0, scx_pkg::IMM4_DUP_ELEM, 5'b00000, 1'b1, 1'b0));
		issue_word(copy_word(1'b1, 4'h3, 5'b10000, 1'b1, 1'b0));
		issue_word(copy_word(1'b0, 4'h2, 5'b00001, 1'b1, 1'b0));
		issue_word(copy_word(1'b0, 4'hF, 5'b00100, 1'b0, 1'b0));
		w = copy_word(1'b0, scx_pkg::IMM4_DUP_GEN, 5'b00010, 1'b1, 1'b0);
		w.decode_word = ~scx_pkg::COPY_MATCH;
		issue_word(w);
		w = copy_word(1'b0, scx_pkg::IMM4_DUP_GEN, 5'b00100, 1'b1, 1'b0);
		w.program_counter = '1;
		issue_word(w);
		// Negative and zero elements through SMOV and UMOV.
		w = copy_word(1'b0, scx_pkg::IMM4_SMOV, 5'b11111, 1'b1, 1'b0);
		w.source_vec_low = '1;
		w.source_vec_high = '1;
		issue_word(w);
		w = copy_word(1'b0, scx_pkg::IMM4_SMOV, 5'b00010, 1'b0, 1'b0);
		w.source_vec_low = 64'h0000_0000_0000_8000;
		issue_word(w);
		w = copy_word(1'b0, scx_pkg::IMM4_UMOV, 5'b00001, 1'b0, 1'b0);
		w.source_vec_low = '0;
		w.source_vec_high = '0;
		issue_word(w);

		for (int n = 0; n < 1600; n++) begin
			if (n >= 1400) begin
				calm = 1'b1;
			end
			issue_word(random_word());
		end
		item_valid <= 1'b0;

		while (tracker.owed_writebacks.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("** simd_copy_execute: PASSED **");
		end else begin
			$display("** simd_copy_execute: FAILED **");
		end
		$finish;
	end
endmodule
